// ===== hdl/iee_pkg.sv =====
// Shared types, constants and codes for the infix expression evaluator.
`timescale 1ns / 1ps
`default_nettype none
package iee_pkg;
	localparam int VALUE_DEPTH_DEF    = 16;
	localparam int OPERATOR_DEPTH_DEF = 16;
	localparam int WORD_WIDTH_DEF     = 32;

	localparam logic [2:0] OP_LPAREN = 3'd0;
	localparam logic [2:0] OP_ADD    = 3'd1;
	localparam logic [2:0] OP_SUB    = 3'd2;
	localparam logic [2:0] OP_MUL    = 3'd3;
	localparam logic [2:0] OP_DIV    = 3'd4;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_OVERFLOW  = 3'd1;
	localparam logic [2:0] ST_MALFORMED = 3'd2;
	localparam logic [2:0] ST_DIVIDE    = 3'd3;
	localparam logic [2:0] ST_BADCHAR   = 3'd4;

	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;

	// datapath commands
	typedef struct packed {
		logic clear;      // reset all stack/number state
		logic digit;      // accumulate digit from char
		logic flush;      // push accumulator if active
		logic push_op;    // push op code
		logic [2:0] op;
		logic pop_op;     // drop top operator
		logic reduce;     // start reduction of top operator
	} iee_cmd_t;

	typedef struct packed {
		logic busy;         // datapath working on a command
		logic err_valid;    // error reported by last command
		logic [2:0] err;
		logic [2:0] top_op;
		logic op_empty;
		logic one_value;
	} iee_stat_t;

	function automatic logic [1:0] rank(input logic [2:0] op);
		case (op)
			OP_ADD, OP_SUB: rank = 2'd1;
			OP_MUL, OP_DIV: rank = 2'd2;
			default:        rank = 2'd0;
		endcase
	endfunction
endpackage
`default_nettype wire

// ===== hdl/infix_expression_evaluator_unit.sv =====
// Top level of the infix integer expression evaluator.
`timescale 1ns / 1ps
`default_nettype none
// Evaluates an infix integer expression fed one ASCII character per input beat
// (digits, space, + - * / ( )), with tlast marking the final character. The
// result beat carries the 32-bit value and a status (0 ok, 1 stack overflow,
// 2 malformed, 3 divide error, 4 bad character); the value is zero on error.
// An operator or right parenthesis may trigger reductions of stacked
// operators; a division runs on the bit-serial divider. After the final
// character the last number is pushed, the remaining operators are reduced
// and the result beat follows. The controller handles one character at a
// time and holds input off while a result beat waits.
module infix_expression_evaluator_unit #(
	parameter int VALUE_DEPTH    = iee_pkg::VALUE_DEPTH_DEF,
	parameter int OPERATOR_DEPTH = iee_pkg::OPERATOR_DEPTH_DEF,
	parameter int WORD_WIDTH     = iee_pkg::WORD_WIDTH_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,   // [7:0] char_code
	input  wire         s_tlast,
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [39:0] m_tdata    // [31:0] result_value, [34:32] status
);
	import iee_pkg::*;

	iee_cmd_t              cmd;
	iee_stat_t             stat;
	logic [WORD_WIDTH-1:0] bottom;
	logic [2:0]            rstat;
	logic [31:0]           value;

	iee_control u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready),
		.char_code(s_tdata), .last_char(s_tlast),
		.stat(stat), .cmd(cmd),
		.res_valid(m_tvalid), .res_status(rstat), .res_ready(m_tready)
	);

	iee_datapath #(
		.VALUE_DEPTH(VALUE_DEPTH), .OPERATOR_DEPTH(OPERATOR_DEPTH),
		.WORD_WIDTH(WORD_WIDTH)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .char_code(s_tdata),
		.cmd(cmd), .stat(stat), .bottom_value(bottom)
	);

	// sign-extend or truncate the word to 32 bits
	assign value = 32'($signed(bottom));

	assign m_tdata = {5'd0, rstat, (rstat == ST_OK) ? value : 32'd0};
endmodule
`default_nettype wire

// ===== hdl/iee_datapath.sv =====
// Stacks, number builder, ALU and serial divider of the evaluator.
`timescale 1ns / 1ps
`default_nettype none
module iee_datapath #(
	parameter int VALUE_DEPTH    = iee_pkg::VALUE_DEPTH_DEF,
	parameter int OPERATOR_DEPTH = iee_pkg::OPERATOR_DEPTH_DEF,
	parameter int WORD_WIDTH     = iee_pkg::WORD_WIDTH_DEF
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire [7:0]              char_code,
	input  iee_pkg::iee_cmd_t      cmd,
	output iee_pkg::iee_stat_t     stat,
	output logic [WORD_WIDTH-1:0]  bottom_value
);
	import iee_pkg::*;

	localparam int VW = $clog2(VALUE_DEPTH + 1);
	localparam int OW = $clog2(OPERATOR_DEPTH + 1);
	localparam int VI = $clog2(VALUE_DEPTH);
	localparam int OI = $clog2(OPERATOR_DEPTH);
	localparam int CW = $clog2(WORD_WIDTH + 1);
	localparam logic [WORD_WIDTH-1:0] SIGN = {1'b1, {(WORD_WIDTH-1){1'b0}}};

	localparam logic [2:0] DS_IDLE = 3'd0;
	localparam logic [2:0] DS_RDB  = 3'd1;
	localparam logic [2:0] DS_RDA  = 3'd2;
	localparam logic [2:0] DS_EXEC = 3'd3;
	localparam logic [2:0] DS_DIV  = 3'd4;
	localparam logic [2:0] DS_WB   = 3'd5;

	logic [WORD_WIDTH-1:0] vmem [VALUE_DEPTH];
	logic [2:0]            omem [OPERATOR_DEPTH];
	logic [VW-1:0]         vcnt_q;
	logic [OW-1:0]         ocnt_q;
	logic [WORD_WIDTH-1:0] acc_q;
	logic                  active_q;
	logic [2:0]            top_q;
	logic [WORD_WIDTH-1:0] bottom_q;
	logic [2:0]            state_q;
	logic [2:0]            rop_q;
	logic [WORD_WIDTH-1:0] rd_q, a_q, b_q;
	logic [WORD_WIDTH-1:0] rem_q, quo_q, den_q;
	logic [CW-1:0]         cnt_q;
	logic                  neg_q;
	logic                  err_v_q;
	logic [2:0]            err_q;

	logic [WORD_WIDTH-1:0] res_word;
	logic [WORD_WIDTH-1:0] acc_next;
	logic [WORD_WIDTH-1:0] mag_a, mag_b;
	logic [WORD_WIDTH:0]   trial;
	logic [WORD_WIDTH-1:0] rem_sh;

	assign acc_next = WORD_WIDTH'(acc_q * WORD_WIDTH'(10))
		+ WORD_WIDTH'(char_code - CH_ZERO);
	assign mag_a = a_q[WORD_WIDTH-1] ? (~a_q + 1'b1) : a_q;
	assign mag_b = b_q[WORD_WIDTH-1] ? (~b_q + 1'b1) : b_q;
	assign rem_sh = {rem_q[WORD_WIDTH-2:0], quo_q[WORD_WIDTH-1]};
	assign trial = {1'b0, rem_sh} - {1'b0, den_q};

	// reads at a signal-chosen address are registered
	always_ff @(posedge clk) begin
		if (state_q == DS_RDB || state_q == DS_RDA)
			rd_q <= vmem[VI'(vcnt_q - 1'b1)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcnt_q   <= '0;
			ocnt_q   <= '0;
			acc_q    <= '0;
			active_q <= 1'b0;
			state_q  <= DS_IDLE;
			err_v_q  <= 1'b0;
			err_q    <= ST_OK;
			top_q    <= OP_LPAREN;
			cnt_q    <= '0;
		end else begin
			err_v_q <= 1'b0;
			if (cmd.clear) begin
				vcnt_q   <= '0;
				ocnt_q   <= '0;
				acc_q    <= '0;
				active_q <= 1'b0;
			end else if (cmd.digit) begin
				acc_q    <= acc_next;
				active_q <= 1'b1;
			end else if (cmd.flush && active_q) begin
				acc_q    <= '0;
				active_q <= 1'b0;
				if (vcnt_q >= VW'(VALUE_DEPTH)) begin
					err_v_q <= 1'b1;
					err_q   <= ST_OVERFLOW;
				end else begin
					vcnt_q <= vcnt_q + 1'b1;
				end
			end else if (cmd.push_op) begin
				if (ocnt_q >= OW'(OPERATOR_DEPTH)) begin
					err_v_q <= 1'b1;
					err_q   <= ST_OVERFLOW;
				end else begin
					ocnt_q <= ocnt_q + 1'b1;
					top_q  <= cmd.op;
				end
			end else if (cmd.pop_op) begin
				ocnt_q <= ocnt_q - 1'b1;
				if (ocnt_q > OW'(1))
					top_q <= omem[OI'(ocnt_q - OW'(2))];
			end
			unique case (state_q)
				DS_IDLE: begin
					if (cmd.reduce) begin
						rop_q  <= top_q;
						ocnt_q <= ocnt_q - 1'b1;
						if (ocnt_q > OW'(1))
							top_q <= omem[OI'(ocnt_q - OW'(2))];
						if (top_q == OP_LPAREN || vcnt_q < VW'(2)) begin
							err_v_q <= 1'b1;
							err_q   <= ST_MALFORMED;
						end else begin
							state_q <= DS_RDB;
						end
					end
				end
				DS_RDB: begin
					vcnt_q  <= vcnt_q - 1'b1;
					state_q <= DS_RDA;
				end
				DS_RDA: begin
					b_q     <= rd_q;
					vcnt_q  <= vcnt_q - 1'b1;
					state_q <= DS_EXEC;
				end
				DS_EXEC: begin
					a_q <= rd_q;
					state_q <= DS_WB;
					if (rop_q == OP_DIV)
						state_q <= DS_DIV;
					cnt_q <= '0;
				end
				DS_DIV: begin
					if (cnt_q == '0) begin
						if (b_q == '0 || (a_q == SIGN && b_q == '1)) begin
							err_v_q <= 1'b1;
							err_q   <= ST_DIVIDE;
							state_q <= DS_IDLE;
						end else begin
							rem_q <= '0;
							quo_q <= mag_a;
							den_q <= mag_b;
							neg_q <= a_q[WORD_WIDTH-1] ^ b_q[WORD_WIDTH-1];
							cnt_q <= cnt_q + 1'b1;
						end
					end else begin
						if (trial[WORD_WIDTH]) begin
							rem_q <= rem_sh;
							quo_q <= {quo_q[WORD_WIDTH-2:0], 1'b0};
						end else begin
							rem_q <= trial[WORD_WIDTH-1:0];
							quo_q <= {quo_q[WORD_WIDTH-2:0], 1'b1};
						end
						if (cnt_q == CW'(WORD_WIDTH))
							state_q <= DS_WB;
						cnt_q <= cnt_q + 1'b1;
					end
				end
				DS_WB: begin
					vcnt_q  <= vcnt_q + 1'b1;
					state_q <= DS_IDLE;
				end
				default: state_q <= DS_IDLE;
			endcase
		end
	end

	always_comb begin
		case (rop_q)
			OP_ADD:  res_word = a_q + b_q;
			OP_SUB:  res_word = a_q - b_q;
			OP_MUL:  res_word = WORD_WIDTH'(a_q * b_q);
			default: res_word = neg_q ? (~quo_q + 1'b1) : quo_q;
		endcase
	end

	// stack writes
	always_ff @(posedge clk) begin
		if (!cmd.clear && !cmd.digit && cmd.flush && active_q
				&& vcnt_q < VW'(VALUE_DEPTH)) begin
			vmem[VI'(vcnt_q)] <= acc_q;
			if (vcnt_q == '0)
				bottom_q <= acc_q;
		end else if (state_q == DS_WB) begin
			vmem[VI'(vcnt_q)] <= res_word;
			if (vcnt_q == '0)
				bottom_q <= res_word;
		end
		if (!cmd.clear && !cmd.digit && !(cmd.flush && active_q) && cmd.push_op
				&& ocnt_q < OW'(OPERATOR_DEPTH))
			omem[OI'(ocnt_q)] <= cmd.op;
	end

	assign bottom_value   = bottom_q;
	assign stat.busy      = (state_q != DS_IDLE);
	assign stat.err_valid = err_v_q;
	assign stat.err       = err_q;
	assign stat.top_op    = top_q;
	assign stat.op_empty  = (ocnt_q == '0);
	assign stat.one_value = (vcnt_q == VW'(1));

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vcnt_q <= VW'(VALUE_DEPTH) && ocnt_q <= OW'(OPERATOR_DEPTH))
		else $error("stack count beyond depth");
	a_reduce_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.reduce |-> state_q == DS_IDLE)
		else $error("reduce issued while busy");
	a_wb_follow: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == DS_WB |=> state_q == DS_IDLE)
		else $error("writeback did not finish");
endmodule
`default_nettype wire

// ===== hdl/iee_control.sv =====
// Character decoder and sequencing state machine of the evaluator.
`timescale 1ns / 1ps
`default_nettype none
module iee_control (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	input  wire [7:0]         char_code,
	input  wire               last_char,
	input  iee_pkg::iee_stat_t stat,
	output iee_pkg::iee_cmd_t cmd,
	output logic              res_valid,
	output logic [2:0]        res_status,
	input  wire               res_ready
);
	import iee_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_FLUSH  = 3'd1;
	localparam logic [2:0] S_CHK    = 3'd2;
	localparam logic [2:0] S_LOOP   = 3'd3;
	localparam logic [2:0] S_END    = 3'd4;
	localparam logic [2:0] S_FFLUSH = 3'd5;
	localparam logic [2:0] S_OUT    = 3'd6;

	// what the reduce loop is working for
	localparam logic [1:0] K_OP  = 2'd0;
	localparam logic [1:0] K_RP  = 2'd1;
	localparam logic [1:0] K_LP  = 2'd2;
	localparam logic [1:0] K_ALL = 2'd3;

	logic [2:0] state_q;
	logic [7:0] ch_q;
	logic       last_q;
	logic [2:0] sticky_q;
	logic [1:0] kind_q;
	logic [2:0] op_q;
	logic       out_q;
	logic [2:0] ostat_q;
	logic       accept;
	logic       is_digit;
	logic [2:0] sticky_now;
	logic       loop_go;

	assign accept = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign is_digit = char_code >= CH_ZERO && char_code <= CH_NINE;
	assign sticky_now = (stat.err_valid && sticky_q == ST_OK) ? stat.err : sticky_q;
	assign res_valid = out_q;
	assign res_status = ostat_q;

	always_comb begin
		unique case (kind_q)
			K_OP:    loop_go = !stat.op_empty && rank(stat.top_op) >= rank(op_q);
			K_RP:    loop_go = !stat.op_empty && stat.top_op != OP_LPAREN;
			K_ALL:   loop_go = !stat.op_empty;
			default: loop_go = 1'b0;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.op = op_q;
		unique case (state_q)
			S_IDLE:   cmd.digit = accept && is_digit && sticky_now == ST_OK;
			S_FLUSH:  cmd.flush = 1'b1;
			S_FFLUSH: cmd.flush = (sticky_now == ST_OK);
			S_LOOP: begin
				// errors and counts of the last command are visible here
				if (!stat.busy && sticky_now == ST_OK) begin
					if (loop_go)
						cmd.reduce = 1'b1;
					else if (kind_q inside {K_OP, K_LP})
						cmd.push_op = 1'b1;
					else if (kind_q == K_RP)
						cmd.pop_op = !stat.op_empty;
				end
			end
			S_OUT:    cmd.clear = res_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			sticky_q <= ST_OK;
			out_q    <= 1'b0;
			ostat_q  <= ST_OK;
			last_q   <= 1'b0;
			kind_q   <= K_ALL;
			op_q     <= OP_ADD;
			ch_q     <= '0;
		end else begin
			sticky_q <= sticky_now;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						ch_q   <= char_code;
						last_q <= last_char;
						if (sticky_now == ST_OK && !is_digit)
							state_q <= S_FLUSH;
						else if (last_char)
							state_q <= S_FFLUSH;
					end
				end
				S_FLUSH: state_q <= S_CHK;
				S_CHK: begin
					// classify the character once the number has gone in
					kind_q  <= K_OP;
					op_q    <= OP_ADD;
					state_q <= S_LOOP;
					unique case (ch_q)
						CH_LPAREN: begin kind_q <= K_LP; op_q <= OP_LPAREN; end
						CH_RPAREN: kind_q <= K_RP;
						CH_PLUS:   op_q <= OP_ADD;
						CH_MINUS:  op_q <= OP_SUB;
						CH_STAR:   op_q <= OP_MUL;
						CH_SLASH:  op_q <= OP_DIV;
						CH_SPACE:  state_q <= S_END;
						default: begin
							state_q <= S_END;
							if (sticky_now == ST_OK)
								sticky_q <= ST_BADCHAR;
						end
					endcase
					if (sticky_now != ST_OK)
						state_q <= S_END;
				end
				S_LOOP: begin
					if (!stat.busy && (sticky_now != ST_OK || !loop_go)) begin
						if (kind_q == K_ALL) begin
							out_q   <= 1'b1;
							ostat_q <= (sticky_now == ST_OK && !stat.one_value)
								? ST_MALFORMED : sticky_now;
							state_q <= S_OUT;
						end else begin
							state_q <= S_END;
						end
					end
				end
				S_END: state_q <= last_q ? S_FFLUSH : S_IDLE;
				S_FFLUSH: begin
					// push the last number, then reduce everything
					kind_q  <= K_ALL;
					state_q <= S_LOOP;
				end
				S_OUT: begin
					if (res_ready) begin
						out_q    <= 1'b0;
						sticky_q <= ST_OK;
						last_q   <= 1'b0;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_out_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_q |-> state_q == S_OUT)
		else $error("result shown outside output state");
	a_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> !in_ready)
		else $error("input taken while working");
	a_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(sticky_q != ST_OK && state_q != S_OUT) |=> sticky_q == $past(sticky_q))
		else $error("first error lost");
endmodule
`default_nettype wire
